// File: hdl/fbst_pkg.sv
// Shared types, codes and constants of the focus/break session timer.
// No dependencies; every other file refers to it by scoped names.
package fbst_pkg;

   localparam int MINUTE_W   = 11;
   localparam int MINS_W     = 16;
   localparam int SECS_W     = 22;
   localparam int CYCLE_W    = 8;
   localparam int SLOT_W     = 24;
   localparam int WORD_W     = 48;
   localparam int WCOUNT_W   = 3;
   localparam int WIDX_W     = 2;
   localparam int MODE_W     = 4;
   localparam int HOUR_FLD_W = 5;
   localparam int MIN_FLD_W  = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;

   // Mode flag bit positions.
   localparam int MODE_ENABLE     = 0;
   localparam int MODE_WINDOW     = 1;
   localparam int MODE_AUTO_BREAK = 2;
   localparam int MODE_AUTO_FOCUS = 3;

   localparam logic [MINS_W-1:0]  FOCUS_MINS_RST = 16'd25;
   localparam logic [MINS_W-1:0]  BREAK_MINS_RST = 16'd5;
   localparam logic [CYCLE_W-1:0] LIMIT_RST      = 8'd4;
   localparam logic [SECS_W-1:0]  SECS_PER_MIN   = 22'd60;
   localparam logic [MINUTE_W-1:0] MINS_PER_HOUR = 11'd60;
   localparam logic [HOUR_FLD_W-1:0] HOUR_MAX    = 5'd23;
   localparam logic [MIN_FLD_W-1:0]  MINUTE_MAX  = 6'd59;

   typedef enum logic [1:0] {
      PH_STOP  = 2'd0,
      PH_FOCUS = 2'd1,
      PH_BREAK = 2'd2
   } fbst_phase_type;

   typedef enum logic [1:0] {
      FN_TICK   = 2'd0,
      FN_START  = 2'd1,
      FN_STOP   = 2'd2,
      FN_TOGGLE = 2'd3
   } fbst_func_type;

   typedef enum logic [WCOUNT_W-1:0] {
      REG_MODE   = 3'd0,
      REG_FOCUS  = 3'd1,
      REG_BREAK  = 3'd2,
      REG_LIMIT  = 3'd3,
      REG_WCOUNT = 3'd4,
      REG_WLOW   = 3'd5,
      REG_WHIGH  = 3'd6
   } fbst_reg_type;

   typedef struct packed {
      fbst_phase_type      phase;
      logic [CYCLE_W-1:0]  cycle;
      logic [SECS_W-1:0]   secs;
      logic [SECS_W-1:0]   len;
      logic                wvalid;
      logic [WIDX_W-1:0]   widx;
   } fbst_state_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [SECS_W-1:0]   focus_secs;
      logic [SECS_W-1:0]   break_secs;
      logic [CYCLE_W-1:0]  cycle_limit;
      logic                wcheck;
   } fbst_cfg_type;

   typedef struct packed {
      logic                hit;
      logic [WIDX_W-1:0]   idx;
   } fbst_win_type;

   // Stage length in seconds; a zero length counts as one minute.
   function automatic logic [SECS_W-1:0] fbst_stage_secs(input logic [MINS_W-1:0] mins);
      logic [SECS_W-1:0] m;
      m = (mins == '0) ? SECS_W'(1) : SECS_W'(mins);
      return SECS_W'(m * SECS_PER_MIN);
   endfunction

endpackage

// File: hdl/fbst_win_match.sv
// Time-of-day window matcher: finds the first enabled window holding the minute.
// Depends on fbst_pkg.
module fbst_win_match #(
   parameter int MAX_WINDOWS = 4
) (
   input  logic [fbst_pkg::WORD_W-1:0]   windows_low,
   input  logic [fbst_pkg::WORD_W-1:0]   windows_high,
   input  logic [fbst_pkg::WCOUNT_W-1:0] window_count,
   input  logic [fbst_pkg::MINUTE_W-1:0] minute_of_day,
   output fbst_pkg::fbst_win_type        win
);

   localparam logic [fbst_pkg::WCOUNT_W-1:0] MaxWin = fbst_pkg::WCOUNT_W'(MAX_WINDOWS);

   logic [2*fbst_pkg::WORD_W-1:0]   all_slots;
   logic [fbst_pkg::WCOUNT_W-1:0]   count_used;
   logic [MAX_WINDOWS-1:0]          hit;

   assign all_slots  = {windows_high, windows_low};
   assign count_used = (window_count > MaxWin) ? MaxWin : window_count;

   always_comb begin
      logic [fbst_pkg::SLOT_W-1:0]     slot;
      logic [fbst_pkg::HOUR_FLD_W-1:0] sh, eh;
      logic [fbst_pkg::MIN_FLD_W-1:0]  sm, em;
      logic [fbst_pkg::MINUTE_W-1:0]   t_start, t_end;
      logic                            in_win;
      hit = '0;
      for (int i = 0; i < MAX_WINDOWS; i++) begin
         slot = all_slots[i*fbst_pkg::SLOT_W +: fbst_pkg::SLOT_W];
         sh = (slot[4:0] > fbst_pkg::HOUR_MAX) ? fbst_pkg::HOUR_MAX : slot[4:0];
         sm = (slot[10:5] > fbst_pkg::MINUTE_MAX) ? fbst_pkg::MINUTE_MAX : slot[10:5];
         eh = (slot[15:11] > fbst_pkg::HOUR_MAX) ? fbst_pkg::HOUR_MAX : slot[15:11];
         em = (slot[21:16] > fbst_pkg::MINUTE_MAX) ? fbst_pkg::MINUTE_MAX : slot[21:16];
         t_start = fbst_pkg::MINUTE_W'(fbst_pkg::MINUTE_W'(sh) * fbst_pkg::MINS_PER_HOUR)
                   + fbst_pkg::MINUTE_W'(sm);
         t_end   = fbst_pkg::MINUTE_W'(fbst_pkg::MINUTE_W'(eh) * fbst_pkg::MINS_PER_HOUR)
                   + fbst_pkg::MINUTE_W'(em);
         // A window whose start lies after its end runs over midnight.
         if (t_start <= t_end) begin
            in_win = (minute_of_day >= t_start) && (minute_of_day <= t_end);
         end else begin
            in_win = (minute_of_day >= t_start) || (minute_of_day <= t_end);
         end
         hit[i] = (fbst_pkg::WCOUNT_W'(i) < count_used) && slot[22] && in_win;
      end
   end

   always_comb begin
      win.hit = |hit;
      win.idx = '0;
      for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            win.idx = fbst_pkg::WIDX_W'(i);
         end
      end
   end

endmodule

// File: hdl/fbst_step.sv
// Next-state logic for one request: tick countdown, stage changes and commands.
// Depends on fbst_pkg.
module fbst_step (
   input  fbst_pkg::fbst_state_type       cur,
   input  fbst_pkg::fbst_cfg_type         cfg,
   input  fbst_pkg::fbst_win_type         win,
   input  fbst_pkg::fbst_func_type        func,
   input  logic                           reminder_busy,
   output fbst_pkg::fbst_state_type       nxt,
   output logic                           stage_started,
   output logic                           start_refused
);

   logic                         running;
   logic                         enabled;
   logic                         wact;
   logic [fbst_pkg::CYCLE_W-1:0] limit;

   assign running = (cur.phase != fbst_pkg::PH_STOP);
   assign enabled = cfg.mode[fbst_pkg::MODE_ENABLE];
   assign limit   = (cfg.cycle_limit == '0) ? fbst_pkg::CYCLE_W'(1) : cfg.cycle_limit;
   // Within a tick that reaches the countdown, a window is active exactly when checked.
   assign wact    = cfg.mode[fbst_pkg::MODE_WINDOW] && cfg.wcheck;

   always_comb begin
      nxt           = cur;
      stage_started = 1'b0;
      start_refused = 1'b0;
      case (func)
         fbst_pkg::FN_TICK: begin
            if (cfg.wcheck && !win.hit) begin
               nxt.wvalid = 1'b0;
               nxt.widx   = '0;
               if (running) begin
                  nxt.phase = fbst_pkg::PH_STOP;
                  nxt.cycle = '0;
                  nxt.secs  = '0;
                  nxt.len   = '0;
               end
            end else if (cfg.wcheck && !running) begin
               nxt.wvalid    = 1'b1;
               nxt.widx      = win.idx;
               nxt.phase     = fbst_pkg::PH_FOCUS;
               nxt.cycle     = fbst_pkg::CYCLE_W'(1);
               nxt.secs      = cfg.focus_secs;
               nxt.len       = cfg.focus_secs;
               stage_started = 1'b1;
            end else begin
               nxt.wvalid = cfg.wcheck;
               nxt.widx   = cfg.wcheck ? win.idx : '0;
               if (running) begin
                  if (cur.secs > fbst_pkg::SECS_W'(1)) begin
                     nxt.secs = cur.secs - fbst_pkg::SECS_W'(1);
                  end else begin
                     nxt.secs = '0;
                     case (cur.phase)
                        fbst_pkg::PH_FOCUS: begin
                           if ((wact || cur.cycle < limit) &&
                               (wact || cfg.mode[fbst_pkg::MODE_AUTO_BREAK])) begin
                              nxt.phase     = fbst_pkg::PH_BREAK;
                              nxt.secs      = cfg.break_secs;
                              nxt.len       = cfg.break_secs;
                              stage_started = 1'b1;
                           end else begin
                              nxt.phase = fbst_pkg::PH_STOP;
                              nxt.cycle = '0;
                              nxt.len   = '0;
                           end
                        end
                        fbst_pkg::PH_BREAK: begin
                           // A busy reminder holds the break end with zero seconds left.
                           if (!reminder_busy) begin
                              if (wact || cfg.mode[fbst_pkg::MODE_AUTO_FOCUS]) begin
                                 if (wact) begin
                                    nxt.cycle = (cur.cycle >= limit) ? fbst_pkg::CYCLE_W'(1)
                                                : cur.cycle + fbst_pkg::CYCLE_W'(1);
                                 end else begin
                                    nxt.cycle = cur.cycle + fbst_pkg::CYCLE_W'(1);
                                 end
                                 nxt.phase     = fbst_pkg::PH_FOCUS;
                                 nxt.secs      = cfg.focus_secs;
                                 nxt.len       = cfg.focus_secs;
                                 stage_started = 1'b1;
                              end else begin
                                 nxt.phase = fbst_pkg::PH_STOP;
                                 nxt.cycle = '0;
                                 nxt.len   = '0;
                              end
                           end
                        end
                        default: begin
                           nxt.phase = fbst_pkg::PH_STOP;
                           nxt.cycle = '0;
                           nxt.len   = '0;
                        end
                     endcase
                  end
               end
            end
         end
         fbst_pkg::FN_STOP: begin
            nxt.phase = fbst_pkg::PH_STOP;
            nxt.cycle = '0;
            nxt.secs  = '0;
            nxt.len   = '0;
         end
         fbst_pkg::FN_START, fbst_pkg::FN_TOGGLE: begin
            if (func == fbst_pkg::FN_TOGGLE && running) begin
               nxt.phase = fbst_pkg::PH_STOP;
               nxt.cycle = '0;
               nxt.secs  = '0;
               nxt.len   = '0;
            end else if (enabled) begin
               nxt.phase     = fbst_pkg::PH_FOCUS;
               nxt.cycle     = fbst_pkg::CYCLE_W'(1);
               nxt.secs      = cfg.focus_secs;
               nxt.len       = cfg.focus_secs;
               stage_started = 1'b1;
            end else begin
               start_refused = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// File: hdl/focus_break_session_timer_top.sv
// Top level of the focus/break session timer: handshakes, configuration registers,
// session state and the request and response registers. Depends on fbst_pkg,
// fbst_win_match and fbst_step. A request waits in the request register until the
// response register can advance; one request per cycle unless it stalls. The state
// update lies between the request and response registers. Reset (synchronous, active
// high) stops the session and loads the register defaults; ready rises after reset.
module focus_break_session_timer_top #(
   parameter int MAX_WINDOWS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tdata: minute_of_day [10:0], reminder_busy [11], zero [15:12]
   input  logic [fbst_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_tuser: func [1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tdata: phase [1:0], seconds_left [23:2], stage_length [45:24],
   // cycle_number [53:46], window_valid [54], window_index [56:55],
   // stage_started [57], start_refused [58], zero [63:59]
   output logic [fbst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbst_pkg::WCOUNT_W-1:0]     csr_index,
   input  logic [fbst_pkg::WORD_W-1:0]       csr_data
);

   // Configuration registers; stage lengths are kept in seconds.
   logic [fbst_pkg::MODE_W-1:0]    mode_ff;
   logic [fbst_pkg::SECS_W-1:0]    focus_secs_ff;
   logic [fbst_pkg::SECS_W-1:0]    break_secs_ff;
   logic [fbst_pkg::CYCLE_W-1:0]   limit_ff;
   logic [fbst_pkg::WCOUNT_W-1:0]  wcount_ff;
   logic [fbst_pkg::WORD_W-1:0]    wlow_ff;
   logic [fbst_pkg::WORD_W-1:0]    whigh_ff;

   fbst_pkg::fbst_state_type       state_ff, state_in, step_state;

   logic                           live_ff;
   logic                           req_valid_ff;
   fbst_pkg::fbst_func_type        req_func_ff;
   logic [fbst_pkg::MINUTE_W-1:0]  req_minute_ff;
   logic                           req_busy_ff;

   logic                           rsp_valid_ff;
   logic [fbst_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                           advance;
   logic                           fire;
   logic                           req_accept;
   logic                           csr_write;
   logic [fbst_pkg::MODE_W-1:0]    mode_in;
   logic                           started, refused;

   fbst_pkg::fbst_cfg_type         cfg;
   fbst_pkg::fbst_win_type         win;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = req_valid_ff && advance;
   assign req_tready = live_ff && (advance || !req_valid_ff);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = live_ff;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cfg.mode        = mode_ff;
   assign cfg.focus_secs  = focus_secs_ff;
   assign cfg.break_secs  = break_secs_ff;
   assign cfg.cycle_limit = limit_ff;
   assign cfg.wcheck      = mode_ff[fbst_pkg::MODE_ENABLE] && mode_ff[fbst_pkg::MODE_WINDOW]
                            && (wcount_ff != '0);

   fbst_win_match #(
      .MAX_WINDOWS (MAX_WINDOWS)
   ) u_win_match (
      .windows_low   (wlow_ff),
      .windows_high  (whigh_ff),
      .window_count  (wcount_ff),
      .minute_of_day (req_minute_ff),
      .win           (win)
   );

   fbst_step u_step (
      .cur           (state_ff),
      .cfg           (cfg),
      .win           (win),
      .func          (req_func_ff),
      .reminder_busy (req_busy_ff),
      .nxt           (step_state),
      .stage_started (started),
      .start_refused (refused)
   );

   assign mode_in = (csr_index == fbst_pkg::REG_MODE) ? csr_data[fbst_pkg::MODE_W-1:0]
                    : mode_ff;

   always_comb begin
      state_in = state_ff;
      if (csr_write && csr_index <= fbst_pkg::REG_WHIGH) begin
         // Any register write drops the window status; disabling stops a session.
         state_in.wvalid = 1'b0;
         state_in.widx   = '0;
         if (!mode_in[fbst_pkg::MODE_ENABLE]) begin
            state_in.phase = fbst_pkg::PH_STOP;
            state_in.cycle = '0;
            state_in.secs  = '0;
            state_in.len   = '0;
         end
      end else if (fire) begin
         state_in = step_state;
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[1:0]   = step_state.phase;
      rsp_data_in[23:2]  = step_state.secs;
      rsp_data_in[45:24] = step_state.len;
      rsp_data_in[53:46] = step_state.cycle;
      rsp_data_in[54]    = step_state.wvalid;
      rsp_data_in[56:55] = step_state.wvalid ? step_state.widx : '0;
      rsp_data_in[57]    = started;
      rsp_data_in[58]    = refused;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         focus_secs_ff <= fbst_pkg::fbst_stage_secs(fbst_pkg::FOCUS_MINS_RST);
         break_secs_ff <= fbst_pkg::fbst_stage_secs(fbst_pkg::BREAK_MINS_RST);
         limit_ff      <= fbst_pkg::LIMIT_RST;
         wcount_ff     <= '0;
         wlow_ff       <= '0;
         whigh_ff      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            fbst_pkg::REG_MODE:   mode_ff <= csr_data[fbst_pkg::MODE_W-1:0];
            fbst_pkg::REG_FOCUS:
               focus_secs_ff <= fbst_pkg::fbst_stage_secs(csr_data[fbst_pkg::MINS_W-1:0]);
            fbst_pkg::REG_BREAK:
               break_secs_ff <= fbst_pkg::fbst_stage_secs(csr_data[fbst_pkg::MINS_W-1:0]);
            fbst_pkg::REG_LIMIT:  limit_ff  <= csr_data[fbst_pkg::CYCLE_W-1:0];
            fbst_pkg::REG_WCOUNT: wcount_ff <= csr_data[fbst_pkg::WCOUNT_W-1:0];
            fbst_pkg::REG_WLOW:   wlow_ff   <= csr_data;
            fbst_pkg::REG_WHIGH:  whigh_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase  <= fbst_pkg::PH_STOP;
         state_ff.cycle  <= '0;
         state_ff.secs   <= '0;
         state_ff.len    <= '0;
         state_ff.wvalid <= 1'b0;
         state_ff.widx   <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_accept) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_func_ff   <= fbst_pkg::fbst_func_type'(req_tuser);
         req_minute_ff <= req_tdata[fbst_pkg::MINUTE_W-1:0];
         req_busy_ff   <= req_tdata[fbst_pkg::MINUTE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
